### hw/rtl/bsd_pkg.sv
`default_nettype none

package bsd_pkg;

    localparam int LENGTH_BITS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int TOTAL_W         = 16;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 16'hFFFF;
    localparam int MAX_CHARS       = 3;

    localparam logic [7:0] BACKSLASH  = 8'h5C;
    localparam logic [7:0] CHAR_N     = 8'h6E;
    localparam logic [7:0] CHAR_R     = 8'h72;
    localparam logic [7:0] CHAR_T     = 8'h74;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_SEVEN = 8'h37;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_TAB   = 8'h09;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } in_t;

    typedef struct packed {
        logic [7:0]         out_byte;
        logic               has_byte;
        logic               last;
        logic [TOTAL_W-1:0] total_length;
    } out_t;

    // decoded characters of one input item
    typedef struct packed {
        logic [MAX_CHARS-1:0][7:0] chars;
        logic [1:0]                n_chars;
        logic                      last;
        logic [TOTAL_W-1:0]        total_length;
    } group_t;

endpackage

`default_nettype wire

### hw/rtl/bsd_front.sv
`default_nettype none

module bsd_front #(
    parameter int LENGTH_BITS = bsd_pkg::LENGTH_BITS_DEF
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire bsd_pkg::in_t   s_data,
    output logic                push_valid,
    input  wire logic           push_ready,
    output bsd_pkg::group_t     push_data
);

    typedef enum logic [1:0] {
        PLAIN,
        ESC,
        DIG1,
        DIG2
    } mode_t;

    mode_t                  mode_reg, mode_next;
    logic [2:0]             fd_reg, fd_next;
    logic [2:0]             sd_reg, sd_next;
    logic [LENGTH_BITS-1:0] count_reg, count_next;

    logic                   take;
    logic [LENGTH_BITS:0]   sum;
    logic [LENGTH_BITS-1:0] count_sat;
    logic [31:0]            count_wide;
    bsd_pkg::group_t        grp;

    // items that only update escape state produce no group
    assign s_ready    = push_ready;
    assign push_valid = s_valid && ((grp.n_chars != 2'd0) || grp.last);
    assign take       = s_valid && push_ready;
    assign push_data  = grp;

    always_comb begin
        logic [7:0] b;
        logic       oct;
        logic [2:0] d;
        b         = s_data.in_byte;
        oct       = b inside {[bsd_pkg::CHAR_ZERO:bsd_pkg::CHAR_SEVEN]};
        d         = b[2:0];
        mode_next = mode_reg;
        fd_next   = fd_reg;
        sd_next   = sd_reg;
        grp       = '0;

        case (mode_reg)
            PLAIN: begin
                if (b == bsd_pkg::BACKSLASH) begin
                    mode_next = ESC;
                end else begin
                    grp.chars[0] = b;
                    grp.n_chars  = 2'd1;
                end
            end
            ESC: begin
                mode_next   = PLAIN;
                grp.n_chars = 2'd1;
                if (b == bsd_pkg::BACKSLASH) begin
                    grp.chars[0] = bsd_pkg::BACKSLASH;
                end else if (b == bsd_pkg::CHAR_N) begin
                    grp.chars[0] = bsd_pkg::CHAR_LF;
                end else if (b == bsd_pkg::CHAR_R) begin
                    grp.chars[0] = bsd_pkg::CHAR_CR;
                end else if (b == bsd_pkg::CHAR_T) begin
                    grp.chars[0] = bsd_pkg::CHAR_TAB;
                end else if (oct) begin
                    fd_next     = d;
                    mode_next   = DIG1;
                    grp.n_chars = 2'd0;
                end else begin
                    grp.chars[0] = b;
                end
            end
            DIG1: begin
                if (oct) begin
                    sd_next   = d;
                    mode_next = DIG2;
                end else begin
                    mode_next    = PLAIN;
                    grp.chars[0] = bsd_pkg::CHAR_ZERO | {5'd0, fd_reg};
                    if (b == bsd_pkg::BACKSLASH) begin
                        mode_next   = ESC;
                        grp.n_chars = 2'd1;
                    end else begin
                        grp.chars[1] = b;
                        grp.n_chars  = 2'd2;
                    end
                end
            end
            default: begin
                mode_next = PLAIN;
                if (oct) begin
                    grp.chars[0] = {fd_reg[1:0], sd_reg, d};
                    grp.n_chars  = 2'd1;
                end else begin
                    grp.chars[0] = bsd_pkg::CHAR_ZERO | {5'd0, fd_reg};
                    grp.chars[1] = bsd_pkg::CHAR_ZERO | {5'd0, sd_reg};
                    if (b == bsd_pkg::BACKSLASH) begin
                        mode_next   = ESC;
                        grp.n_chars = 2'd2;
                    end else begin
                        grp.chars[2] = b;
                        grp.n_chars  = 2'd3;
                    end
                end
            end
        endcase

        // end of string: flush held digits, drop a lone backslash
        if (s_data.end_of_string) begin
            if (mode_next == DIG1) begin
                grp.chars[0] = bsd_pkg::CHAR_ZERO | {5'd0, fd_next};
                grp.n_chars  = 2'd1;
            end else if (mode_next == DIG2) begin
                grp.chars[0] = bsd_pkg::CHAR_ZERO | {5'd0, fd_next};
                grp.chars[1] = bsd_pkg::CHAR_ZERO | {5'd0, sd_next};
                grp.n_chars  = 2'd2;
            end
            mode_next = PLAIN;
            fd_next   = '0;
            sd_next   = '0;
        end

        sum        = {1'b0, count_reg} + (LENGTH_BITS + 1)'(grp.n_chars);
        count_sat  = sum[LENGTH_BITS] ? {LENGTH_BITS{1'b1}} : sum[LENGTH_BITS-1:0];
        count_wide = 32'(count_sat);
        count_next = count_sat;
        if (s_data.end_of_string) begin
            grp.last         = 1'b1;
            grp.total_length = (count_wide > 32'(bsd_pkg::TOTAL_MAX)) ?
                               bsd_pkg::TOTAL_MAX : count_wide[bsd_pkg::TOTAL_W-1:0];
            count_next       = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= PLAIN;
            fd_reg    <= '0;
            sd_reg    <= '0;
            count_reg <= '0;
        end else if (take) begin
            mode_reg  <= mode_next;
            fd_reg    <= fd_next;
            sd_reg    <= sd_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/bsd_queue.sv
`default_nettype none

module bsd_queue #(
    parameter int DEPTH = bsd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire bsd_pkg::group_t  push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output bsd_pkg::group_t       pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bsd_pkg::group_t    mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_reg, wr_next;
    logic [PTR_W-1:0]   rd_reg, rd_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic               push, pop;

    assign push_ready = fill_reg != CNT_W'(DEPTH);
    assign pop_valid  = fill_reg != '0;
    assign pop_data   = mem_reg[rd_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        wr_next   = wr_reg;
        rd_next   = rd_reg;
        fill_next = fill_reg;
        if (push) begin
            wr_next = (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop) begin
            rd_next = (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end else begin
            wr_reg   <= wr_next;
            rd_reg   <= rd_next;
            fill_reg <= fill_next;
        end
    end

    ap_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(DEPTH))
        else $error("queue fill above depth");

    ap_fill_step: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> fill_reg == $past(fill_reg) + 1'b1)
        else $error("queue fill not incremented on write");

    ap_ptr_match: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg == '0 |-> wr_reg == rd_reg)
        else $error("queue empty with pointers apart");

endmodule

`default_nettype wire

### hw/rtl/bsd_back.sv
`default_nettype none

module bsd_back (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             pop_valid,
    output logic                  pop_ready,
    input  wire bsd_pkg::group_t  pop_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output bsd_pkg::out_t         m_data
);

    logic            m_valid_reg, m_valid_next;
    bsd_pkg::out_t   m_data_reg, m_data_next;
    logic [1:0]      idx_reg, idx_next;

    logic            final_char;
    logic            load;
    logic [1:0]      cnt_m1;
    logic [7:0]      sel_char;

    assign m_valid    = m_valid_reg;
    assign m_data     = m_data_reg;
    assign cnt_m1     = (pop_data.n_chars == 2'd0) ? 2'd0 : pop_data.n_chars - 2'd1;
    assign final_char = idx_reg == cnt_m1;
    assign load       = pop_valid && (!m_valid_reg || m_ready);
    assign pop_ready  = load && final_char;

    always_comb begin
        case (idx_reg)
            2'd0:    sel_char = pop_data.chars[0];
            2'd1:    sel_char = pop_data.chars[1];
            default: sel_char = pop_data.chars[2];
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        idx_next     = idx_reg;
        if (load) begin
            m_valid_next          = 1'b1;
            m_data_next.has_byte  = pop_data.n_chars != 2'd0;
            m_data_next.out_byte  = (pop_data.n_chars != 2'd0) ? sel_char : 8'd0;
            m_data_next.last      = pop_data.last && final_char;
            m_data_next.total_length = (pop_data.last && final_char) ?
                                       pop_data.total_length : '0;
            idx_next              = final_char ? 2'd0 : idx_reg + 2'd1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            idx_reg     <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    ap_marker_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_data_reg.has_byte |-> m_data_reg.last)
        else $error("bare end marker without last");

    ap_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pop_valid |-> idx_reg <= cnt_m1)
        else $error("result index beyond group");

    ap_idx_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        pop_ready && pop_valid |=> idx_reg == 2'd0)
        else $error("result index not cleared after group");

endmodule

`default_nettype wire

### hw/rtl/backslash_escape_decoder_unit.sv
`default_nettype none

// Path: each group goes through the group queue, and each result leaves from the output register.
// Throughput: one input transfer per cycle while the group queue has room; the result side
// drains one result per cycle while the receiver takes them; an item that decodes to k characters
// gives k results (a bare end marker gives one, an item that only holds escape state none).
// Reset (aresetn low, synchronous): plain mode, length count zero, queue and output empty.

module backslash_escape_decoder_unit #(
    parameter int LENGTH_BITS = bsd_pkg::LENGTH_BITS_DEF,
    parameter int QUEUE_DEPTH = bsd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire bsd_pkg::in_t   s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output bsd_pkg::out_t       m_data
);

    logic            push_valid, push_ready;
    bsd_pkg::group_t push_data;
    logic            pop_valid, pop_ready;
    bsd_pkg::group_t pop_data;

    bsd_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    bsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    bsd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

### sim/tb_backslash_escape_decoder_unit.sv
`timescale 1ns / 1ps

module tb_backslash_escape_decoder_unit;

    localparam int STALL_LIMIT = 5000;
    localparam int RANDOM_ITEMS = 344;
    localparam int DIR_ROWS = 26;

    typedef enum logic [1:0] {PLAIN, ESC, OCT1, OCT2} esc_mode_t;

    typedef struct packed {
        logic                  pinned;
        logic [1:0]            n;
        bsd_pkg::out_t [2:0]   res;
    } pin_t;

    typedef struct packed {
        bsd_pkg::in_t item;
        pin_t         pin;
    } row_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    bsd_pkg::in_t  s_data = '0;
    pin_t          s_pin = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    bsd_pkg::out_t m_data;

    backslash_escape_decoder_unit u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // unescape state mirror
    esc_mode_t     dec_mode = PLAIN;
    logic [2:0]    dec_d1 = '0;
    logic [2:0]    dec_d2 = '0;
    logic [15:0]   dec_len = '0;
    logic [7:0]    dec_chars [3];
    int            dec_n;
    bsd_pkg::out_t pred_res [3];
    int            pred_n;

    bsd_pkg::out_t decoded_q [$];
    int            mismatches = 0;
    int            stall_cycles = 0;

    function automatic void put_char(logic [7:0] c);
        if (dec_n < 3) begin
            dec_chars[dec_n] = c;
            dec_n++;
        end
        if (dec_len != bsd_pkg::TOTAL_MAX) dec_len++;
    endfunction

    function automatic void scan_char(logic [7:0] c);
        if (c == bsd_pkg::BACKSLASH) dec_mode = ESC;
        else put_char(c);
    endfunction

    function automatic bit is_oct(logic [7:0] c);
        return c >= bsd_pkg::CHAR_ZERO && c <= bsd_pkg::CHAR_SEVEN;
    endfunction

    function automatic logic [7:0] digit_char(logic [2:0] d);
        return bsd_pkg::CHAR_ZERO + 8'(d);
    endfunction

    function automatic void decode_item(bsd_pkg::in_t it);
        logic [7:0] c;
        c = it.in_byte;
        dec_n = 0;
        case (dec_mode)
            PLAIN: scan_char(c);
            ESC: begin
                dec_mode = PLAIN;
                if (c == bsd_pkg::BACKSLASH) put_char(bsd_pkg::BACKSLASH);
                else if (c == bsd_pkg::CHAR_N) put_char(bsd_pkg::CHAR_LF);
                else if (c == bsd_pkg::CHAR_R) put_char(bsd_pkg::CHAR_CR);
                else if (c == bsd_pkg::CHAR_T) put_char(bsd_pkg::CHAR_TAB);
                else if (is_oct(c)) begin
                    dec_d1 = c[2:0];
                    dec_mode = OCT1;
                end else put_char(c);
            end
            OCT1: begin
                if (is_oct(c)) begin
                    dec_d2 = c[2:0];
                    dec_mode = OCT2;
                end else begin
                    dec_mode = PLAIN;
                    put_char(digit_char(dec_d1));
                    scan_char(c);
                end
            end
            default: begin
                dec_mode = PLAIN;
                if (is_oct(c)) begin
                    put_char(8'({dec_d1, dec_d2, c[2:0]}));
                end else begin
                    put_char(digit_char(dec_d1));
                    put_char(digit_char(dec_d2));
                    scan_char(c);
                end
            end
        endcase
        if (it.end_of_string) begin
            if (dec_mode == OCT1) begin
                put_char(digit_char(dec_d1));
            end else if (dec_mode == OCT2) begin
                put_char(digit_char(dec_d1));
                put_char(digit_char(dec_d2));
            end
            dec_mode = PLAIN;
        end
        for (int k = 0; k < dec_n; k++) pred_res[k] = '{dec_chars[k], 1'b1, 1'b0, 16'h0};
        pred_n = dec_n;
        if (it.end_of_string) begin
            if (pred_n == 0) begin
                pred_res[0] = '0;
                pred_n = 1;
            end
            pred_res[pred_n-1].last = 1'b1;
            pred_res[pred_n-1].total_length = dec_len;
            dec_len = '0;
            dec_d1 = '0;
            dec_d2 = '0;
        end
    endfunction

    // prediction on input transfers, compare on output transfers
    always @(posedge aclk) begin : scoreboard
        bsd_pkg::out_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                decode_item(s_data);
                if (s_pin.pinned) begin
                    for (int k = 0; k < s_pin.n; k++) decoded_q.push_back(s_pin.res[k]);
                end else begin
                    for (int k = 0; k < pred_n; k++) decoded_q.push_back(pred_res[k]);
                end
            end
            if (m_valid && m_ready) begin
                if (decoded_q.size() == 0) begin
                    $error("unexpected result transfer: out_byte %0h", m_data.out_byte);
                    mismatches++;
                end else begin
                    want = decoded_q.pop_front();
                    if (m_data.out_byte !== want.out_byte) begin
                        $error("out_byte: expected %0h, got %0h", want.out_byte, m_data.out_byte);
                        mismatches++;
                    end
                    if (m_data.has_byte !== want.has_byte) begin
                        $error("has_byte: expected %0b, got %0b", want.has_byte, m_data.has_byte);
                        mismatches++;
                    end
                    if (m_data.last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, m_data.last);
                        mismatches++;
                    end
                    if (m_data.total_length !== want.total_length) begin
                        $error("total_length: expected %0d, got %0d",
                               want.total_length, m_data.total_length);
                        mismatches++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT) begin
            $display("tb_backslash_escape_decoder_unit: errors");
            $finish;
        end
    end

    // receiver stall pattern
    int   rx_left = 0;
    int   rx_style = 0;
    logic [2:0] rx_tick = '0;

    always @(posedge aclk) begin
        rx_tick <= rx_tick + 1'b1;
        if (rx_left == 0) begin
            rx_style <= $urandom_range(0, 3);
            rx_left <= $urandom_range(16, 128);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_style)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= (rx_tick != 3'd5);
        endcase
    end

    // sender
    int burst_left = 0;

    task automatic push_item(bsd_pkg::in_t it, pin_t pin);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                      : $urandom_range(1, 24);
        end
        s_valid <= 1'b1;
        s_data <= it;
        s_pin <= pin;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (decoded_q.size() != 0) @(posedge aclk);
    endtask

    function automatic bsd_pkg::out_t chr(logic [7:0] b, logic lst = 1'b0,
                                          logic [15:0] len = '0);
        return '{b, 1'b1, lst, len};
    endfunction

    function automatic row_t row(logic [7:0] b, logic e);
        return '{'{b, e}, pin_t'('0)};
    endfunction

    function automatic row_t pin_row(logic [7:0] b, logic e, logic [1:0] n,
                                     bsd_pkg::out_t r0, bsd_pkg::out_t r1 = '0);
        row_t r;
        r.item = '{b, e};
        r.pin.pinned = 1'b1;
        r.pin.n = n;
        r.pin.res = {bsd_pkg::out_t'('0), r1, r0};
        return r;
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255)); while (b == bsd_pkg::BACKSLASH);
        return b;
    endfunction

    function automatic logic [7:0] rand_digit();
        return bsd_pkg::CHAR_ZERO + 8'($urandom_range(0, 7));
    endfunction

    logic [7:0] str_q [$];

    task automatic gen_string();
        int ntok;
        logic [7:0] simple [4];
        simple = '{bsd_pkg::BACKSLASH, bsd_pkg::CHAR_N, bsd_pkg::CHAR_R, bsd_pkg::CHAR_T};
        str_q.delete();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 10)) str_q.push_back(8'($urandom_range(1, 255)));
            return;
        end
        ntok = $urandom_range(1, 6);
        repeat (ntok) begin
            case ($urandom_range(0, 7))
                0, 1, 2: repeat ($urandom_range(1, 3)) str_q.push_back(plain_byte());
                3: begin
                    str_q.push_back(bsd_pkg::BACKSLASH);
                    str_q.push_back(simple[$urandom_range(0, 3)]);
                end
                4: begin
                    str_q.push_back(bsd_pkg::BACKSLASH);
                    repeat (3) str_q.push_back(rand_digit());
                end
                5: begin
                    str_q.push_back(bsd_pkg::BACKSLASH);
                    repeat ($urandom_range(1, 2)) str_q.push_back(rand_digit());
                end
                6: begin
                    str_q.push_back(bsd_pkg::BACKSLASH);
                    str_q.push_back(8'($urandom_range(1, 255)));
                end
                default: begin
                    str_q.push_back(bsd_pkg::BACKSLASH);
                    str_q.push_back(rand_digit());
                    str_q.push_back(rand_digit());
                    str_q.push_back(8'($urandom_range(1, 255)));
                end
            endcase
        end
        if ($urandom_range(0, 7) == 0) str_q.push_back(bsd_pkg::BACKSLASH);
    endtask

    row_t dir_tab [DIR_ROWS];
    int   random_sent = 0;

    initial begin
        dir_tab = '{
            pin_row(8'h41, 1'b1, 2'd1, chr(8'h41, 1'b1, 16'd1)),
            pin_row(8'hFF, 1'b0, 2'd1, chr(8'hFF)),
            pin_row(bsd_pkg::BACKSLASH, 1'b1, 2'd1, '{8'h00, 1'b0, 1'b1, 16'd1}),
            row(bsd_pkg::BACKSLASH, 1'b0),
            pin_row(bsd_pkg::BACKSLASH, 1'b0, 2'd1, chr(bsd_pkg::BACKSLASH)),
            row(bsd_pkg::BACKSLASH, 1'b0),
            pin_row(bsd_pkg::CHAR_N, 1'b0, 2'd1, chr(bsd_pkg::CHAR_LF)),
            row(bsd_pkg::BACKSLASH, 1'b0),
            pin_row(bsd_pkg::CHAR_R, 1'b0, 2'd1, chr(bsd_pkg::CHAR_CR)),
            row(bsd_pkg::BACKSLASH, 1'b0),
            pin_row(bsd_pkg::CHAR_T, 1'b0, 2'd1, chr(bsd_pkg::CHAR_TAB)),
            row(bsd_pkg::BACKSLASH, 1'b0),
            row(bsd_pkg::CHAR_SEVEN, 1'b0),
            row(bsd_pkg::CHAR_SEVEN, 1'b0),
            pin_row(bsd_pkg::CHAR_SEVEN, 1'b0, 2'd1, chr(8'hFF)),
            row(bsd_pkg::BACKSLASH, 1'b0),
            row(8'h32, 1'b0),
            row(8'h35, 1'b0),
            row(bsd_pkg::BACKSLASH, 1'b0),
            row(8'h7A, 1'b0),
            row(bsd_pkg::BACKSLASH, 1'b0),
            row(8'h31, 1'b0),
            row(8'h78, 1'b0),
            row(bsd_pkg::BACKSLASH, 1'b0),
            row(8'h34, 1'b0),
            pin_row(8'h36, 1'b1, 2'd2, chr(8'h34), chr(8'h36, 1'b1, 16'd12))
        };

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tab[i]) push_item(dir_tab[i].item, dir_tab[i].pin);
        settle();

        while (random_sent < RANDOM_ITEMS) begin
            gen_string();
            foreach (str_q[i]) push_item('{str_q[i], i == str_q.size() - 1}, '0);
            random_sent += str_q.size();
            if ($urandom_range(0, 15) == 0) settle();
        end

        settle();
        repeat (8) @(posedge aclk);
        if (decoded_q.size() != 0) begin
            $error("%0d expected results never arrived", decoded_q.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("tb_backslash_escape_decoder_unit: clean");
        end else begin
            $display("tb_backslash_escape_decoder_unit: errors");
        end
        $finish;
    end

endmodule
